// ===== sv/spq_pkg.sv =====
// shared types and constants for the sorted priority queue
// no dependencies; imported by the controller, datapath and top level
package spq_pkg;

    localparam logic [1:0] OP_ENQ  = 2'd0;
    localparam logic [1:0] OP_DEQ  = 2'd1;
    localparam logic [1:0] OP_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic signed [31:0] priority_req;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] out_value;
        logic signed [31:0] out_priority;
    } t_rsp;

    // output side: no result waiting, or one result held
    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    typedef struct packed {
        logic       enq;
        logic       deq;
        logic       load_rsp;
        logic       head_sel;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_status;

endpackage

// ===== sv/spq_ctrl.sv =====
// controller for the sorted priority queue: handshake state machine and op decode
// depends on spq_pkg
module spq_ctrl
    import spq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_status i_dp_status,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall  = (r_state == S_HOLD) && i_out_stall;
    assign o_out_valid = (r_state == S_HOLD);
    assign accept      = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (r_state)
            S_IDLE: n_state = accept ? S_HOLD : S_IDLE;
            S_HOLD: begin
                if (accept) begin
                    n_state = S_HOLD;
                end else if (!i_out_stall) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load_rsp = accept;
        o_cmd.status   = ST_OK;
        if (accept) begin
            unique case (i_op)
                OP_ENQ: begin
                    o_cmd.enq    = !i_dp_status.full;
                    o_cmd.status = i_dp_status.full ? ST_FULL : ST_OK;
                end
                OP_DEQ: begin
                    o_cmd.deq      = !i_dp_status.empty;
                    o_cmd.head_sel = !i_dp_status.empty;
                    o_cmd.status   = i_dp_status.empty ? ST_EMPTY : ST_OK;
                end
                OP_PEEK: begin
                    o_cmd.head_sel = !i_dp_status.empty;
                    o_cmd.status   = i_dp_status.empty ? ST_EMPTY : ST_OK;
                end
                default: o_cmd.status = ST_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a held result goes away only when it was taken
    a_hold_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) && i_out_stall |=> r_state == S_HOLD)
        else $error("held result dropped while stalled");

    a_no_enq_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.enq |-> !i_dp_status.full)
        else $error("insert issued on a full queue");

    a_no_deq_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.deq |-> !i_dp_status.empty && o_cmd.head_sel)
        else $error("remove issued on an empty queue");

endmodule

// ===== sv/spq_datapath.sv =====
// datapath for the sorted priority queue: row of compare-and-shift cells,
// entry count and result register; depends on spq_pkg
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_req       i_req,
    input  t_cmd       i_cmd,
    output t_dp_status o_dp_status,
    output t_rsp       o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] r_val  [DEPTH];
    logic signed [31:0] r_prio [DEPTH];
    logic signed [31:0] n_val  [DEPTH];
    logic signed [31:0] n_prio [DEPTH];
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    t_rsp               r_rsp;
    logic [DEPTH-1:0]   ge;

    assign o_dp_status.full  = (r_count == CW'(DEPTH));
    assign o_dp_status.empty = (r_count == '0);
    assign o_rsp             = r_rsp;

    // held entries form a prefix; ge marks those that stay ahead of the newcomer
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CW'(i) < r_count) && !(r_prio[i] < i_req.priority_req);
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] up_val;
        logic signed [31:0] up_prio;
        logic signed [31:0] dn_val;
        logic signed [31:0] dn_prio;
        logic               ins_here;

        if (g == 0) begin : g_first
            assign up_val   = i_req.value;
            assign up_prio  = i_req.priority_req;
            assign ins_here = !ge[g];
        end else begin : g_mid
            assign up_val   = r_val[g-1];
            assign up_prio  = r_prio[g-1];
            assign ins_here = !ge[g] && ge[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign dn_val  = r_val[g];
            assign dn_prio = r_prio[g];
        end else begin : g_inner
            assign dn_val  = r_val[g+1];
            assign dn_prio = r_prio[g+1];
        end

        always_comb begin
            n_val[g]  = r_val[g];
            n_prio[g] = r_prio[g];
            if (i_cmd.enq && !ge[g]) begin
                // insert here, or make room by taking the neighbor toward the head
                n_val[g]  = ins_here ? i_req.value : up_val;
                n_prio[g] = ins_here ? i_req.priority_req : up_prio;
            end else if (i_cmd.deq) begin
                n_val[g]  = dn_val;
                n_prio[g] = dn_prio;
            end
        end

        always_ff @(posedge i_clk) begin
            r_val[g]  <= n_val[g];
            r_prio[g] <= n_prio[g];
        end
    end

    always_comb begin
        priority if (i_cmd.enq) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.deq) begin
            n_count = r_count - CW'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_rsp) begin
            r_rsp.status       <= i_cmd.status;
            r_rsp.out_value    <= i_cmd.head_sel ? r_val[0] : '0;
            r_rsp.out_priority <= i_cmd.head_sel ? r_prio[0] : '0;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.enq |=> r_count == $past(r_count) + CW'(1))
        else $error("count not advanced on insert");

    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> !(r_prio[0] < r_prio[DEPTH > 1 ? 1 : 0]))
        else $error("head not of highest priority");

endmodule

// ===== sv/sorted_priority_queue.sv =====
// top level of the sorted priority queue: joins controller and datapath
// depends on spq_pkg, spq_ctrl, spq_datapath
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------
//  request | in        | i_in_valid / o_in_stall    | i_in_req
//  result  | out       | o_out_valid / i_out_stall  | o_out_rsp
//
// the cell row compares and shifts in parallel for every request
// the result appears in the output register in the cycle after acceptance
// a new request is taken in the same cycle as the previous result is taken
// o_in_stall is high only while a result is held and i_out_stall is high
// reset clears the entry count and the held state; stored entries and the result register need none
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    t_cmd       cmd;
    t_dp_status dp_status;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_req.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (cmd),
        .o_dp_status (dp_status),
        .o_rsp       (o_out_rsp)
    );

endmodule
